FILE: sv/nearest_waypoint_lookahead_core_macros.svh
// Assertion macros for the nearest-waypoint lookahead core.
// Each macro expects signals named clk and rst in the including scope.
`ifndef NEAREST_WAYPOINT_LOOKAHEAD_CORE_MACROS_SVH
`define NEAREST_WAYPOINT_LOOKAHEAD_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NWL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/nwl_pkg.sv
// Shared types and constants for the nearest-waypoint lookahead core.
// Used by nwl_mem, nwl_dist and nearest_waypoint_lookahead_core; no dependencies.
package nwl_pkg;

  localparam int COORD_W = 32;
  localparam int INDEX_W = 10;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 64;
  localparam int DIST_W  = 65;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  // Travels alongside each table word through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage

FILE: sv/nearest_waypoint_lookahead_core.sv
// Nearest-waypoint lookahead core: waypoint table, nearest search, lookahead emit.
// Depends on nwl_pkg, nwl_mem, nwl_dist and nearest_waypoint_lookahead_core_macros.svh.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | op, entry_index, pos_x, pos_y, last_entry
//   out     | out_valid, out_stall | out_index, out_x, out_y, last_out
//
// A query scans the table, one table read per cycle through the single read
// port, then the distance pipeline drains; each emitted word then passes
// through ST_EM_RD and ST_EM_LD, and ST_EM_LD waits while out is stalled.
// The table has no reset; only the entry count, the control state, the tag pipeline and out_valid clear on rst.
// in_stall is high for the whole query; out_stall holds the output register,
// which in turn holds the emit sequencer.
`include "nearest_waypoint_lookahead_core_macros.svh"

module nearest_waypoint_lookahead_core #(
  parameter int MAX_ENTRIES = 1024,
  parameter int LOOKAHEAD   = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [nwl_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [nwl_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [nwl_pkg::COORD_W-1:0]  pos_y,
  input  logic                                last_entry,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nwl_pkg::INDEX_W-1:0]         out_index,
  output logic signed [nwl_pkg::COORD_W-1:0]  out_x,
  output logic signed [nwl_pkg::COORD_W-1:0]  out_y,
  output logic                                last_out
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = $clog2(LOOKAHEAD + 1);

  nwl_pkg::state_t state;
  nwl_pkg::state_t state_next;

  logic                                in_accept;
  logic                                idx_in_range;
  logic [31:0]                         idx_wide;
  logic [31:0]                         idx_plus1;
  logic                                wr_en;
  logic                                rd_en;
  logic [AW-1:0]                       rd_addr;
  logic [2*nwl_pkg::COORD_W-1:0]       rd_data;
  nwl_pkg::tag_t                       issue_tag;
  nwl_pkg::tag_t                       rd_tag;
  nwl_pkg::tag_t                       cmp_tag;
  logic [nwl_pkg::DIST_W-1:0]          cmp_dist;
  logic                                better;
  logic [CW-1:0]                       best_idx_next;
  logic                                emit_last;
  logic                                out_load;
  logic [31:0]                         ptr_wide;

  logic [CW-1:0]                       count;
  logic signed [nwl_pkg::COORD_W-1:0]  pose_x;
  logic signed [nwl_pkg::COORD_W-1:0]  pose_y;
  logic [CW-1:0]                       scan_i;
  logic [CW-1:0]                       cmp_idx;
  logic [CW-1:0]                       best_idx;
  logic [nwl_pkg::DIST_W-1:0]          best_dist;
  logic [CW-1:0]                       ptr;
  logic [NW-1:0]                       emit_n;

  assign in_accept    = in_valid && !in_stall;
  assign idx_wide     = 32'(entry_index);
  assign idx_plus1    = idx_wide + 32'd1;
  assign idx_in_range = idx_wide < 32'(MAX_ENTRIES);
  assign wr_en        = in_accept && (op == nwl_pkg::OP_LOAD) && idx_in_range;
  assign ptr_wide     = 32'(ptr);

  nwl_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_wide[AW-1:0]),
    .wr_data ({pos_y, pos_x}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nwl_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (rd_tag),
    .wx      (rd_data[nwl_pkg::COORD_W-1:0]),
    .wy      (rd_data[2*nwl_pkg::COORD_W-1:nwl_pkg::COORD_W]),
    .px      (pose_x),
    .py      (pose_y),
    .out_tag (cmp_tag),
    .sq_sum  (cmp_dist)
  );

  // Strict less-than keeps the lower index on a tie.
  assign better        = cmp_tag.valid && (cmp_tag.first || (cmp_dist < best_dist));
  assign best_idx_next = better ? cmp_idx : best_idx;
  assign emit_last     = ((ptr + CW'(1)) == count) || (emit_n == NW'(LOOKAHEAD - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      nwl_pkg::ST_IDLE: begin
        if (in_accept && (op == nwl_pkg::OP_QUERY) && (count != '0)) begin
          state_next = nwl_pkg::ST_SCAN;
        end
      end
      nwl_pkg::ST_SCAN: begin
        if ((scan_i + CW'(1)) == count) begin
          state_next = nwl_pkg::ST_DRAIN;
        end
      end
      nwl_pkg::ST_DRAIN: begin
        if (cmp_tag.valid && cmp_tag.last) begin
          state_next = nwl_pkg::ST_EM_RD;
        end
      end
      nwl_pkg::ST_EM_RD: begin
        state_next = nwl_pkg::ST_EM_LD;
      end
      nwl_pkg::ST_EM_LD: begin
        if (out_load) begin
          state_next = emit_last ? nwl_pkg::ST_IDLE : nwl_pkg::ST_EM_RD;
        end
      end
      default: begin
        state_next = nwl_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer. Loads only happen in idle and table reads only
  // outside it, so a read never meets a write to the same entry.
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = '0;
    issue_tag = '0;
    out_load  = 1'b0;
    case (state)
      nwl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      nwl_pkg::ST_SCAN: begin
        rd_en           = 1'b1;
        rd_addr         = scan_i[AW-1:0];
        issue_tag.valid = 1'b1;
        issue_tag.first = (scan_i == '0);
        issue_tag.last  = ((scan_i + CW'(1)) == count);
      end
      nwl_pkg::ST_EM_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr[AW-1:0];
      end
      nwl_pkg::ST_EM_LD: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nwl_pkg::ST_IDLE;
      count     <= '0;
      rd_tag    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_tag <= issue_tag;
      if (wr_en && last_entry) begin
        count <= idx_plus1[CW-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (op == nwl_pkg::OP_QUERY)) begin
      pose_x  <= pos_x;
      pose_y  <= pos_y;
      scan_i  <= '0;
      cmp_idx <= '0;
    end
    if (state == nwl_pkg::ST_SCAN) begin
      scan_i <= scan_i + CW'(1);
    end
    if (cmp_tag.valid) begin
      cmp_idx <= cmp_idx + CW'(1);
      if (better) begin
        best_idx  <= cmp_idx;
        best_dist <= cmp_dist;
      end
    end
    if ((state == nwl_pkg::ST_DRAIN) && cmp_tag.valid && cmp_tag.last) begin
      ptr    <= best_idx_next;
      emit_n <= '0;
    end
    if (out_load) begin
      out_index <= ptr_wide[nwl_pkg::INDEX_W-1:0];
      out_x     <= rd_data[nwl_pkg::COORD_W-1:0];
      out_y     <= rd_data[2*nwl_pkg::COORD_W-1:nwl_pkg::COORD_W];
      last_out  <= emit_last;
      ptr       <= ptr + CW'(1);
      emit_n    <= emit_n + NW'(1);
    end
  end

  `NWL_ASSERT_IMPL(a_idle_pipe_empty, state == nwl_pkg::ST_IDLE, !cmp_tag.valid,
                   "distance pipeline busy in idle")
  `NWL_ASSERT_NEXT(a_last_cmp_emits, cmp_tag.valid && cmp_tag.last,
                   state == nwl_pkg::ST_EM_RD, "final compare did not start emit")
  `NWL_ASSERT_IMPL(a_scan_in_table, state == nwl_pkg::ST_SCAN, scan_i < count,
                   "scan index beyond entry count")
  `NWL_ASSERT_IMPL(a_emit_in_table,
                   state == nwl_pkg::ST_EM_RD || state == nwl_pkg::ST_EM_LD,
                   ptr < count, "emit pointer beyond entry count")

endmodule

FILE: sv/nwl_mem.sv
// Waypoint table: one synchronous memory holding {y, x} per entry.
// One write port and one read port with registered read data; uses nwl_pkg.
module nwl_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [2*nwl_pkg::COORD_W-1:0]  wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [2*nwl_pkg::COORD_W-1:0]  rd_data
);

  logic [2*nwl_pkg::COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads so a stalled emit can pick it up later.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/nwl_dist.sv
// Three-stage squared Euclidean distance pipeline: abs difference, square, sum.
// The 65-bit result is exact; uses nwl_pkg for widths and the tag type.
module nwl_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  nwl_pkg::tag_t                       in_tag,
  input  logic signed [nwl_pkg::COORD_W-1:0]  wx,
  input  logic signed [nwl_pkg::COORD_W-1:0]  wy,
  input  logic signed [nwl_pkg::COORD_W-1:0]  px,
  input  logic signed [nwl_pkg::COORD_W-1:0]  py,
  output nwl_pkg::tag_t                       out_tag,
  output logic [nwl_pkg::DIST_W-1:0]          sq_sum
);

  logic signed [nwl_pkg::COORD_W:0] diff_x;
  logic signed [nwl_pkg::COORD_W:0] diff_y;
  logic signed [nwl_pkg::COORD_W:0] neg_x;
  logic signed [nwl_pkg::COORD_W:0] neg_y;
  logic [nwl_pkg::MAG_W-1:0]        mag_x_next;
  logic [nwl_pkg::MAG_W-1:0]        mag_y_next;

  nwl_pkg::tag_t                    tag_a;
  nwl_pkg::tag_t                    tag_b;
  logic [nwl_pkg::MAG_W-1:0]        mag_x;
  logic [nwl_pkg::MAG_W-1:0]        mag_y;
  logic [nwl_pkg::SQ_W-1:0]         sq_x;
  logic [nwl_pkg::SQ_W-1:0]         sq_y;

  // The magnitude of a difference of two 32-bit signed values fits 32 bits.
  assign diff_x     = {wx[nwl_pkg::COORD_W-1], wx} - {px[nwl_pkg::COORD_W-1], px};
  assign diff_y     = {wy[nwl_pkg::COORD_W-1], wy} - {py[nwl_pkg::COORD_W-1], py};
  assign neg_x      = -diff_x;
  assign neg_y      = -diff_y;
  assign mag_x_next = diff_x[nwl_pkg::COORD_W] ? neg_x[nwl_pkg::MAG_W-1:0]
                                               : diff_x[nwl_pkg::MAG_W-1:0];
  assign mag_y_next = diff_y[nwl_pkg::COORD_W] ? neg_y[nwl_pkg::MAG_W-1:0]
                                               : diff_y[nwl_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a   <= '0;
      tag_b   <= '0;
      out_tag <= '0;
    end else begin
      tag_a   <= in_tag;
      tag_b   <= tag_a;
      out_tag <= tag_b;
    end
  end

  always_ff @(posedge clk) begin
    mag_x  <= mag_x_next;
    mag_y  <= mag_y_next;
    sq_x   <= nwl_pkg::SQ_W'(mag_x) * nwl_pkg::SQ_W'(mag_x);
    sq_y   <= nwl_pkg::SQ_W'(mag_y) * nwl_pkg::SQ_W'(mag_y);
    sq_sum <= {1'b0, sq_x} + {1'b0, sq_y};
  end

endmodule
